[design/kml_pkg.sv]
// kml_pkg: shared types and constants for the k-means clustering engine
// request/response payload structs, mode, status and register codes, lfsr step
// no dependencies
package kml_pkg;

   // fixed field widths
   localparam int VALUE_W = 24;
   localparam int ITER_W  = 16;
   localparam int LFSR_W  = 16;

   // request modes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FEW  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CLUSTERS = 2'd0;
   localparam logic [1:0] REG_DIMS     = 2'd1;
   localparam logic [1:0] REG_MAX_ITER = 2'd2;
   localparam logic [1:0] REG_SEED     = 2'd3;

   // register reset values
   localparam logic [3:0]  RST_CLUSTERS = 4'd2;
   localparam logic [4:0]  RST_DIMS     = 5'd1;
   localparam logic [15:0] RST_MAX_ITER = 16'd1000;
   localparam logic [15:0] RST_SEED     = 16'd44257;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [VALUE_W-1:0] value;
      logic                      end_of_point;
      logic [2:0]                cluster_sel;
      logic [3:0]                dim_sel;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] center_value;
      logic [ITER_W-1:0]         iterations;
      logic                      converged;
      logic [1:0]                status;
   } rsp_type;

   // fibonacci lfsr, taps 16,14,13,11
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[LFSR_W-1:1]};
   endfunction

endpackage

[design/kmeans_lloyd_clustering.sv]
// kmeans_lloyd_clustering: top level, lloyd k-means engine with point/center/sum memories
// uses kml_pkg (types, codes, lfsr step) and kml_div (mean divider)
//
//  channel  | ports                        | moves
//  ---------+------------------------------+-----------------------------------
//  request  | req_valid, req_stall, req_data | load / run / read request
//  response | rsp_valid, rsp_stall, rsp_data | center value, iterations, status
//  config   | csr_psel .. csr_prdata        | four 32-bit registers at 4*i
//
// run: centers are drawn by the lfsr and copied from point memory; each pass runs through the one
// shared square/accumulate path and the bit-serial divider.
// after reset a clearing pass zeroes center and sum memories.
// a waiting response does not block loads; response stall holds only the next result.
module kmeans_lloyd_clustering import kml_pkg::*; #(
   parameter int MAX_POINTS   = 1024,
   parameter int MAX_DIMS     = 16,
   parameter int MAX_CLUSTERS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PCNT_W  = $clog2(MAX_POINTS + 1);
   localparam int PIDX_W  = $clog2(MAX_POINTS);
   localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NW      = $clog2(MAX_DIMS + 1);
   localparam int CL_W    = $clog2(MAX_CLUSTERS);
   localparam int KW      = $clog2(MAX_CLUSTERS + 1);
   localparam int CDEPTH  = MAX_CLUSTERS * MAX_DIMS;
   localparam int CADDR_W = $clog2(CDEPTH);
   localparam int PDEPTH  = MAX_POINTS * MAX_DIMS;
   localparam int PADDR_W = $clog2(PDEPTH);
   localparam int SUM_W   = VALUE_W + $clog2(MAX_POINTS);
   localparam int MAG_W   = VALUE_W + 1;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int ACC_W   = SQ_W + NW;
   localparam int PROD_W  = PCNT_W + LFSR_W;

   typedef enum logic [22:0] {
      S_CLEAR  = 23'h000001,
      S_IDLE   = 23'h000002,
      S_RESP   = 23'h000004,
      S_RDWAIT = 23'h000008,
      S_INIT   = 23'h000010,
      S_DRAW   = 23'h000020,
      S_DUP    = 23'h000040,
      S_CPRD   = 23'h000080,
      S_CPWR   = 23'h000100,
      S_PASS   = 23'h000200,
      S_PT     = 23'h000400,
      S_DRD    = 23'h000800,
      S_DSUB   = 23'h001000,
      S_DSQ    = 23'h002000,
      S_DACC   = 23'h004000,
      S_CMP    = 23'h008000,
      S_ARD    = 23'h010000,
      S_AWR    = 23'h020000,
      S_URD    = 23'h040000,
      S_UDIV   = 23'h080000,
      S_UWAIT  = 23'h100000,
      S_UWR    = 23'h200000,
      S_PEND   = 23'h400000
   } state_type;

   // configuration registers
   logic [3:0]  nc_ff;
   logic [4:0]  nd_ff;
   logic [15:0] mi_ff;
   logic [15:0] seed_ff;

   // control state
   state_type           state_ff, state_in;
   logic [CADDR_W-1:0]  clr_ff, clr_in;
   logic [PCNT_W-1:0]   pc_ff, pc_in;
   logic [DIM_W-1:0]    cp_ff, cp_in;
   logic                new_set_ff, new_set_in;
   logic [ITER_W-1:0]   last_iter_ff, last_iter_in;
   logic                last_conv_ff, last_conv_in;
   logic [1:0]          last_status_ff, last_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic signed [VALUE_W-1:0] res_cv_ff, res_cv_in;
   logic [1:0]          res_st_ff, res_st_in;
   logic                rd_ok_ff, rd_ok_in;

   // run datapath
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [PIDX_W-1:0]   idx_ff, idx_in;
   logic [PIDX_W-1:0]   chosen_ff [MAX_CLUSTERS];
   logic [PIDX_W-1:0]   chosen_in [MAX_CLUSTERS];
   logic [PCNT_W-1:0]   mcount_ff [MAX_CLUSTERS];
   logic [PCNT_W-1:0]   mcount_in [MAX_CLUSTERS];
   logic [KW-1:0]       c_ff, c_in;
   logic [KW-1:0]       j_ff, j_in;
   logic [NW-1:0]       d_ff, d_in;
   logic [PCNT_W-1:0]   p_ff, p_in;
   logic [CL_W-1:0]     best_ff, best_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    bd_ff, bd_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic signed [VALUE_W-1:0] cold_ff, cold_in;
   logic signed [VALUE_W-1:0] nv_ff, nv_in;
   logic                conv_ff, conv_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;

   // memories and their read registers
   logic signed [VALUE_W-1:0] point_mem_ff  [PDEPTH];
   logic signed [VALUE_W-1:0] center_mem_ff [CDEPTH];
   logic signed [SUM_W-1:0]   sum_mem_ff    [CDEPTH];
   logic signed [VALUE_W-1:0] pm_rd_ff, cm_rd_ff;
   logic signed [SUM_W-1:0]   sm_rd_ff;

   logic                      pm_we, cm_we, sm_we;
   logic [PADDR_W-1:0]        pm_waddr, pm_raddr;
   logic [CADDR_W-1:0]        cm_waddr, cm_raddr, sm_waddr, sm_raddr;
   logic signed [VALUE_W-1:0] pm_wdata, cm_wdata;
   logic signed [SUM_W-1:0]   sm_wdata;

   // effective settings and helpers
   logic [KW-1:0]       k_eff;
   logic [NW-1:0]       n_eff;
   logic [ITER_W-1:0]   cap;
   logic [LFSR_W-1:0]   lfsr_nx;
   logic [PROD_W-1:0]   prod;
   logic [PIDX_W-1:0]   pidx_sel;
   logic [PCNT_W-1:0]   eff_pc;
   logic [DIM_W-1:0]    eff_cp;
   logic signed [MAG_W-1:0] diff;
   logic [CADDR_W-1:0]  cd_addr, bd_addr, rq_addr;
   logic                req_take, rsp_free, last_d, last_c;
   logic                div_start, div_done;
   logic signed [VALUE_W-1:0] div_quo;
   logic [CL_W-1:0]     c_idx;

   // ---------------------------------------------------------------
   // configuration port
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_CLUSTERS: csr_prdata = {28'd0, nc_ff};
         REG_DIMS:     csr_prdata = {27'd0, nd_ff};
         REG_MAX_ITER: csr_prdata = {16'd0, mi_ff};
         REG_SEED:     csr_prdata = {16'd0, seed_ff};
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff   <= RST_CLUSTERS;
         nd_ff   <= RST_DIMS;
         mi_ff   <= RST_MAX_ITER;
         seed_ff <= RST_SEED;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_paddr[3:2])
            REG_CLUSTERS: nc_ff   <= csr_pwdata[3:0];
            REG_DIMS:     nd_ff   <= csr_pwdata[4:0];
            REG_MAX_ITER: mi_ff   <= csr_pwdata[15:0];
            REG_SEED:     seed_ff <= csr_pwdata[15:0];
            default:      nc_ff   <= nc_ff;
         endcase
      end
   end

   // clamped settings
   always_comb begin
      if (nc_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(nc_ff) > MAX_CLUSTERS) begin
         k_eff = KW'(MAX_CLUSTERS);
      end else begin
         k_eff = KW'(nc_ff);
      end
      if (nd_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(nd_ff) > MAX_DIMS) begin
         n_eff = NW'(MAX_DIMS);
      end else begin
         n_eff = NW'(nd_ff);
      end
      cap = (mi_ff == '0) ? ITER_W'(1) : mi_ff;
   end

   // ---------------------------------------------------------------
   // addresses and shared helpers
   assign c_idx    = c_ff[CL_W-1:0];
   assign lfsr_nx  = lfsr_step(lfsr_ff);
   assign prod     = PROD_W'(pc_ff) * PROD_W'(lfsr_nx);
   assign pidx_sel = (state_ff == S_CPRD) ? idx_ff : p_ff[PIDX_W-1:0];
   assign pm_raddr = PADDR_W'(pidx_sel) * PADDR_W'(MAX_DIMS) + PADDR_W'(d_ff);
   assign cd_addr  = CADDR_W'(c_idx) * CADDR_W'(MAX_DIMS) + CADDR_W'(d_ff);
   assign bd_addr  = CADDR_W'(best_ff) * CADDR_W'(MAX_DIMS) + CADDR_W'(d_ff);
   assign rq_addr  = CADDR_W'(req_data.cluster_sel) * CADDR_W'(MAX_DIMS)
                   + CADDR_W'(req_data.dim_sel);
   assign cm_raddr = (state_ff == S_IDLE) ? rq_addr : cd_addr;
   assign sm_raddr = (state_ff == S_ARD) ? bd_addr : cd_addr;
   assign eff_pc   = new_set_ff ? '0 : pc_ff;
   assign eff_cp   = new_set_ff ? '0 : cp_ff;
   assign diff     = MAG_W'(pm_rd_ff) - MAG_W'(cm_rd_ff);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign last_d   = (d_ff + NW'(1)) == n_eff;
   assign last_c   = (c_ff + KW'(1)) == k_eff;
   assign req_stall = (state_ff != S_IDLE);

   // ---------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      pc_in          = pc_ff;
      cp_in          = cp_ff;
      new_set_in     = new_set_ff;
      last_iter_in   = last_iter_ff;
      last_conv_in   = last_conv_ff;
      last_status_in = last_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      res_cv_in      = res_cv_ff;
      res_st_in      = res_st_ff;
      rd_ok_in       = rd_ok_ff;
      lfsr_in        = lfsr_ff;
      idx_in         = idx_ff;
      chosen_in      = chosen_ff;
      mcount_in      = mcount_ff;
      c_in           = c_ff;
      j_in           = j_ff;
      d_in           = d_ff;
      p_in           = p_ff;
      best_in        = best_ff;
      acc_in         = acc_ff;
      bd_in          = bd_ff;
      mag_in         = mag_ff;
      sq_in          = sq_ff;
      cold_in        = cold_ff;
      nv_in          = nv_ff;
      conv_in        = conv_ff;
      iter_in        = iter_ff;
      pm_we          = 1'b0;
      pm_waddr       = PADDR_W'(eff_pc[PIDX_W-1:0]) * PADDR_W'(MAX_DIMS) + PADDR_W'(eff_cp);
      pm_wdata       = req_data.value;
      cm_we          = 1'b0;
      cm_waddr       = cd_addr;
      cm_wdata       = pm_rd_ff;
      sm_we          = 1'b0;
      sm_waddr       = cd_addr;
      sm_wdata       = '0;
      div_start      = 1'b0;

      // response register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // zero center and sum memories after reset
         S_CLEAR: begin
            cm_we    = 1'b1;
            cm_waddr = clr_ff;
            cm_wdata = '0;
            sm_we    = 1'b1;
            sm_waddr = clr_ff;
            clr_in   = clr_ff + CADDR_W'(1);
            if (clr_ff == CADDR_W'(CDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               case (req_data.mode)
                  MODE_LOAD: begin
                     new_set_in = 1'b0;
                     pc_in      = eff_pc;
                     cp_in      = eff_cp;
                     if (32'(eff_pc) >= MAX_POINTS) begin
                        res_cv_in = '0;
                        res_st_in = STATUS_FULL;
                        state_in  = S_RESP;
                     end else begin
                        pm_we = 1'b1;
                        if (req_data.end_of_point) begin
                           pc_in = eff_pc + PCNT_W'(1);
                           cp_in = '0;
                        end else if (32'(eff_cp) == MAX_DIMS - 1) begin
                           cp_in = '0;
                        end else begin
                           cp_in = eff_cp + DIM_W'(1);
                        end
                     end
                  end
                  MODE_RUN: begin
                     new_set_in = 1'b1;
                     res_cv_in  = '0;
                     if (32'(pc_ff) < 32'(k_eff)) begin
                        last_status_in = STATUS_FEW;
                        last_iter_in   = '0;
                        last_conv_in   = 1'b0;
                        res_st_in      = STATUS_FEW;
                        state_in       = S_RESP;
                     end else begin
                        state_in = S_INIT;
                     end
                  end
                  MODE_READ: begin
                     rd_ok_in  = (32'(req_data.cluster_sel) < 32'(k_eff))
                              && (32'(req_data.dim_sel) < 32'(n_eff));
                     res_st_in = last_status_ff;
                     state_in  = S_RDWAIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // center read data arrives
         S_RDWAIT: begin
            res_cv_in = rd_ok_ff ? cm_rd_ff : '0;
            state_in  = S_RESP;
         end

         // hand the result to the output register
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.center_value = res_cv_ff;
               rsp_in.iterations   = last_iter_ff;
               rsp_in.converged    = last_conv_ff;
               rsp_in.status       = res_st_ff;
               state_in            = S_IDLE;
            end
         end

         // initial center draw
         S_INIT: begin
            lfsr_in  = (seed_ff == '0) ? LFSR_W'(1) : seed_ff;
            c_in     = '0;
            state_in = S_DRAW;
         end

         S_DRAW: begin
            lfsr_in  = lfsr_nx;
            idx_in   = prod[LFSR_W +: PIDX_W];
            j_in     = '0;
            state_in = S_DUP;
         end

         // reject an index already chosen
         S_DUP: begin
            if (j_ff == c_ff) begin
               chosen_in[c_idx] = idx_ff;
               d_in             = '0;
               state_in         = S_CPRD;
            end else if (chosen_ff[j_ff[CL_W-1:0]] == idx_ff) begin
               state_in = S_DRAW;
            end else begin
               j_in = j_ff + KW'(1);
            end
         end

         S_CPRD: begin
            state_in = S_CPWR;
         end

         S_CPWR: begin
            cm_we = 1'b1;
            d_in  = d_ff + NW'(1);
            if (last_d) begin
               if (last_c) begin
                  iter_in  = '0;
                  state_in = S_PASS;
               end else begin
                  c_in     = c_ff + KW'(1);
                  state_in = S_DRAW;
               end
            end else begin
               state_in = S_CPRD;
            end
         end

         // start of one lloyd pass
         S_PASS: begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
               mcount_in[i] = '0;
            end
            p_in     = '0;
            state_in = S_PT;
         end

         S_PT: begin
            c_in     = '0;
            d_in     = '0;
            acc_in   = '0;
            state_in = S_DRD;
         end

         // squared distance, one coordinate at a time
         S_DRD: begin
            state_in = S_DSUB;
         end

         S_DSUB: begin
            mag_in   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            state_in = S_DSQ;
         end

         S_DSQ: begin
            sq_in    = mag_ff * mag_ff;
            state_in = S_DACC;
         end

         S_DACC: begin
            acc_in = acc_ff + ACC_W'(sq_ff);
            d_in   = d_ff + NW'(1);
            state_in = last_d ? S_CMP : S_DRD;
         end

         // nearest center, ties to the lower index
         S_CMP: begin
            if (c_ff == '0 || acc_ff < bd_ff) begin
               bd_in   = acc_ff;
               best_in = c_idx;
            end
            d_in = '0;
            if (last_c) begin
               state_in = S_ARD;
            end else begin
               c_in     = c_ff + KW'(1);
               acc_in   = '0;
               state_in = S_DRD;
            end
         end

         // add the point into its cluster sums
         S_ARD: begin
            state_in = S_AWR;
         end

         S_AWR: begin
            sm_we    = 1'b1;
            sm_waddr = bd_addr;
            sm_wdata = sm_rd_ff + SUM_W'(pm_rd_ff);
            d_in     = d_ff + NW'(1);
            if (last_d) begin
               mcount_in[best_ff] = mcount_ff[best_ff] + PCNT_W'(1);
               p_in = p_ff + PCNT_W'(1);
               if ((p_ff + PCNT_W'(1)) == pc_ff) begin
                  c_in     = '0;
                  d_in     = '0;
                  conv_in  = 1'b1;
                  state_in = S_URD;
               end else begin
                  state_in = S_PT;
               end
            end else begin
               state_in = S_ARD;
            end
         end

         // center update from sums
         S_URD: begin
            state_in = S_UDIV;
         end

         S_UDIV: begin
            cold_in = cm_rd_ff;
            if (mcount_ff[c_idx] != '0) begin
               div_start = 1'b1;
               state_in  = S_UWAIT;
            end else begin
               nv_in    = cm_rd_ff;
               state_in = S_UWR;
            end
         end

         S_UWAIT: begin
            if (div_done) begin
               nv_in    = div_quo;
               state_in = S_UWR;
            end
         end

         S_UWR: begin
            cm_we    = 1'b1;
            cm_wdata = nv_ff;
            sm_we    = 1'b1;
            if (nv_ff != cold_ff) begin
               conv_in = 1'b0;
            end
            d_in = d_ff + NW'(1);
            if (last_d) begin
               d_in = '0;
               if (last_c) begin
                  state_in = S_PEND;
               end else begin
                  c_in     = c_ff + KW'(1);
                  state_in = S_URD;
               end
            end else begin
               state_in = S_URD;
            end
         end

         // pass count and stop test
         S_PEND: begin
            iter_in = iter_ff + ITER_W'(1);
            if (conv_ff || ({1'b0, iter_ff} + 17'd1) >= {1'b0, cap}) begin
               last_iter_in   = iter_ff + ITER_W'(1);
               last_conv_in   = conv_ff;
               last_status_in = STATUS_OK;
               res_st_in      = STATUS_OK;
               state_in       = S_RESP;
            end else begin
               state_in = S_PASS;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_ff         <= '0;
         pc_ff          <= '0;
         cp_ff          <= '0;
         new_set_ff     <= 1'b0;
         last_iter_ff   <= '0;
         last_conv_ff   <= 1'b0;
         last_status_ff <= STATUS_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         pc_ff          <= pc_in;
         cp_ff          <= cp_in;
         new_set_ff     <= new_set_in;
         last_iter_ff   <= last_iter_in;
         last_conv_ff   <= last_conv_in;
         last_status_ff <= last_status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff    <= rsp_in;
      res_cv_ff <= res_cv_in;
      res_st_ff <= res_st_in;
      rd_ok_ff  <= rd_ok_in;
      lfsr_ff   <= lfsr_in;
      idx_ff    <= idx_in;
      chosen_ff <= chosen_in;
      mcount_ff <= mcount_in;
      c_ff      <= c_in;
      j_ff      <= j_in;
      d_ff      <= d_in;
      p_ff      <= p_in;
      best_ff   <= best_in;
      acc_ff    <= acc_in;
      bd_ff     <= bd_in;
      mag_ff    <= mag_in;
      sq_ff     <= sq_in;
      cold_ff   <= cold_in;
      nv_ff     <= nv_in;
      conv_ff   <= conv_in;
      iter_ff   <= iter_in;
   end

   // ---------------------------------------------------------------
   // point memory
   always_ff @(posedge clock) begin
      if (pm_we) begin
         point_mem_ff[pm_waddr] <= pm_wdata;
      end
      pm_rd_ff <= point_mem_ff[pm_raddr];
   end

   // center memory
   always_ff @(posedge clock) begin
      if (cm_we) begin
         center_mem_ff[cm_waddr] <= cm_wdata;
      end
      cm_rd_ff <= center_mem_ff[cm_raddr];
   end

   // sum memory
   always_ff @(posedge clock) begin
      if (sm_we) begin
         sum_mem_ff[sm_waddr] <= sm_wdata;
      end
      sm_rd_ff <= sum_mem_ff[sm_raddr];
   end

   // mean divider
   kml_div #(
      .NUM_W (SUM_W),
      .DEN_W (PCNT_W),
      .QUO_W (VALUE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sm_rd_ff),
      .den   (mcount_ff[c_idx]),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/kml_div.sv]
// kml_div: iterative signed-by-unsigned divider, one quotient bit per cycle
// truncates toward zero; used for the center mean update
// no package dependencies
module kml_div #(
   parameter int NUM_W = 34,
   parameter int DEN_W = 11,
   parameter int QUO_W = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic signed [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [QUO_W-1:0] mag;

   // restoring step
   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[NUM_W-1]};
      if (start) begin
         neg_in  = num[NUM_W-1];
         q_in    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign fix of the magnitude quotient
   assign mag  = q_ff[QUO_W-1:0];
   assign quo  = neg_ff ? QUO_W'(-mag) : QUO_W'(mag);
   assign done = done_ff;

endmodule

[test/tb.sv]
// tb: self-checking testbench for the kmeans_lloyd_clustering engine
// holds a scoreboard class with its own k-means predictor, plus request, response and register drivers
// depends on kml_pkg and the kmeans_lloyd_clustering top level
module tb;
   import kml_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = 1024;
   localparam int NDIM = 16;
   localparam int NCLU = 8;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD = 400;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // scoreboard: lloyd predictor and queue of expected responses
   class kmeans_scoreboard;
      longint points[NPTS*NDIM];
      longint centers[NCLU*NDIM];
      int unsigned npoints, coord_ptr;
      int unsigned chosen[NCLU];
      logic [3:0]  reg_k;
      logic [4:0]  reg_n;
      logic [15:0] reg_iter, reg_seed;
      logic [15:0] last_iter;
      logic        last_conv;
      logic [1:0]  last_status;
      bit          fresh_set;
      rsp_type     pending[$];
      int          errors, matched;

      function new();
         foreach (points[i]) points[i] = 0;
         foreach (centers[i]) centers[i] = 0;
         foreach (chosen[i]) chosen[i] = 0;
         npoints = 0;
         coord_ptr = 0;
         reg_k = RST_CLUSTERS;
         reg_n = RST_DIMS;
         reg_iter = RST_MAX_ITER;
         reg_seed = RST_SEED;
         last_iter = 0;
         last_conv = 0;
         last_status = STATUS_OK;
         fresh_set = 0;
         errors = 0;
         matched = 0;
      endfunction

      function int unsigned eff_k();
         if (reg_k == 0) return 1;
         return (reg_k > NCLU) ? NCLU : reg_k;
      endfunction

      function int unsigned eff_n();
         if (reg_n == 0) return 1;
         return (reg_n > NDIM) ? NDIM : reg_n;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_CLUSTERS: reg_k = v[3:0];
            REG_DIMS:     reg_n = v[4:0];
            REG_MAX_ITER: reg_iter = v[15:0];
            REG_SEED:     reg_seed = v[15:0];
            default:      reg_k = reg_k;
         endcase
      endfunction

      function longint unsigned sq_dist(int unsigned p, int unsigned c, int unsigned n);
         longint unsigned acc;
         longint diff;
         acc = 0;
         for (int d = 0; d < n; d++) begin
            diff = points[p*NDIM+d] - centers[c*NDIM+d];
            acc += diff * diff;
         end
         return acc;
      endfunction

      // initial pick by lfsr, then lloyd passes until stable or capped
      function void cluster_run();
         int unsigned k, n, m, it, cap, idx, best;
         bit conv, dup;
         logic [15:0] s;
         longint sums[NCLU*NDIM];
         int unsigned members[NCLU];
         longint unsigned bd, dd;
         longint nv;
         k = eff_k();
         n = eff_n();
         m = npoints;
         if (m < k) begin
            last_status = STATUS_FEW;
            last_iter = 0;
            last_conv = 0;
            return;
         end
         s = (reg_seed != 0) ? reg_seed : 16'd1;
         for (int c = 0; c < k; c++) begin
            do begin
               s = {s[0] ^ s[2] ^ s[3] ^ s[5], s[15:1]};
               idx = (m * s) >> 16;
               dup = 0;
               for (int j = 0; j < c; j++) if (chosen[j] == idx) dup = 1;
            end while (dup);
            chosen[c] = idx;
            for (int d = 0; d < n; d++) centers[c*NDIM+d] = points[idx*NDIM+d];
         end
         cap = (reg_iter != 0) ? reg_iter : 1;
         it = 0;
         conv = 0;
         while (!conv && it < cap) begin
            foreach (sums[i]) sums[i] = 0;
            foreach (members[i]) members[i] = 0;
            for (int p = 0; p < m; p++) begin
               best = 0;
               bd = sq_dist(p, 0, n);
               for (int c = 1; c < k; c++) begin
                  dd = sq_dist(p, c, n);
                  if (dd < bd) begin
                     bd = dd;
                     best = c;
                  end
               end
               members[best]++;
               for (int d = 0; d < n; d++) sums[best*NDIM+d] += points[p*NDIM+d];
            end
            conv = 1;
            for (int c = 0; c < k; c++) begin
               for (int d = 0; d < n; d++) begin
                  nv = centers[c*NDIM+d];
                  if (members[c] != 0) nv = sums[c*NDIM+d] / longint'(members[c]);
                  if (nv != centers[c*NDIM+d]) conv = 0;
                  centers[c*NDIM+d] = nv;
               end
            end
            it++;
         end
         last_iter = it[15:0];
         last_conv = conv;
         last_status = STATUS_OK;
      endfunction

      // update state for an accepted request and queue its response, if any
      function void note_request(req_type r);
         rsp_type e;
         e.center_value = '0;
         e.status = last_status;
         case (r.mode)
            MODE_LOAD: begin
               if (fresh_set) begin
                  npoints = 0;
                  coord_ptr = 0;
                  fresh_set = 0;
               end
               if (npoints < NPTS) begin
                  points[npoints*NDIM+coord_ptr] = longint'(r.value);
                  if (r.end_of_point) begin
                     npoints++;
                     coord_ptr = 0;
                  end else begin
                     coord_ptr = (coord_ptr + 1 >= NDIM) ? 0 : coord_ptr + 1;
                  end
                  return;
               end
               e.status = STATUS_FULL;
            end
            MODE_RUN: begin
               cluster_run();
               fresh_set = 1;
               e.status = last_status;
            end
            MODE_READ: begin
               if (r.cluster_sel < eff_k() && r.dim_sel < eff_n())
                  e.center_value = centers[r.cluster_sel*NDIM+r.dim_sel][23:0];
            end
            default: return;
         endcase
         e.iterations = last_iter;
         e.converged = last_conv;
         pending.push_back(e);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with none expected, status", got.status, 0);
            return;
         end
         want = pending.pop_front();
         if (got.center_value !== want.center_value)
            report_mismatch("center_value", got.center_value, want.center_value);
         if (got.iterations !== want.iterations)
            report_mismatch("iterations", got.iterations, want.iterations);
         if (got.converged !== want.converged)
            report_mismatch("converged", got.converged, want.converged);
         if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
         matched++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kmeans_lloyd_clustering dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   kmeans_scoreboard sb = new();
   int     items_sent = 0;
   int     runs_sent = 0;
   int     burst_left = 0;
   bit     hold_req = 0;
   longint cycles = 0;

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver stall pattern, with one long hold on request
   initial begin
      int pat, len;
      rsp_stall = 0;
      forever begin
         pat = $urandom_range(0, 2);
         len = $urandom_range(1, 60);
         repeat (len) begin
            @(negedge clock);
            if (hold_req) begin
               rsp_stall <= 1;
               repeat (LONG_HOLD) @(negedge clock);
               hold_req = 0;
            end else if (pat == 0) rsp_stall <= 0;
            else if (pat == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 4) != 0);
         end
      end
   end

   // register write, setup then access; called at a falling edge
   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // offer one request until accepted, then continue the burst or gap
   task automatic send_req(req_type r);
      int gap;
      req_data <= r;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.mode != MODE_NONE) items_sent++;
      if (r.mode == MODE_RUN) runs_sent++;
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // sender pause until every expected response is back
   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic req_type make_req(logic [1:0] mode, int v, bit eop, int cs, int ds);
      req_type r;
      r.mode = mode;
      r.value = v[23:0];
      r.end_of_point = eop;
      r.cluster_sel = cs[2:0];
      r.dim_sel = ds[3:0];
      return r;
   endfunction

   function automatic int coord_near(int base);
      if ($urandom_range(0, 7) == 0) return $urandom;
      return base + $urandom_range(0, 8191) - 4096;
   endfunction

   // one point set: loads, a run, then center reads with some noise
   task automatic point_set_group(bit long_hold);
      int k, n, m, cl, ncoord, nr, cs, ds;
      int base[NCLU][NDIM];
      k = sb.eff_k();
      n = sb.eff_n();
      foreach (base[i, j]) base[i][j] = $urandom_range(0, 1 << 23) - (1 << 22);
      // at least one point, so every run works on a set loaded at this width
      if (k > 1 && $urandom_range(0, 9) == 0) m = $urandom_range(1, k - 1);
      else m = $urandom_range(k, k + ((n > 4) ? 2 : 6));
      for (int p = 0; p < m; p++) begin
         cl = $urandom_range(0, k - 1);
         ncoord = ($urandom_range(0, 15) == 0) ? n + NDIM : n;
         for (int c = 0; c < ncoord; c++)
            send_req(make_req(MODE_LOAD, coord_near(base[cl][c % NDIM]), c == ncoord - 1,
                              $urandom, $urandom));
      end
      // unfinished point left behind
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, n))
            send_req(make_req(MODE_LOAD, $urandom, 0, $urandom, $urandom));
      send_req(make_req(MODE_RUN, $urandom, $urandom, $urandom, $urandom));
      if (long_hold) hold_req = 1;
      nr = long_hold ? 40 : $urandom_range(3, 10);
      repeat (nr) begin
         cs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, k - 1);
         ds = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
         send_req(make_req(MODE_READ, $urandom, $urandom, cs, ds));
         if ($urandom_range(0, 5) == 0)
            send_req(make_req(MODE_NONE, $urandom, $urandom, $urandom, $urandom));
      end
      if ($urandom_range(0, 7) == 0)
         send_req(make_req(MODE_RUN, $urandom, $urandom, $urandom, $urandom));
   endtask

   // stimulus
   initial begin
      int ph, groups, k_val, n_val, it_val, sd_val;
      req_valid = 0;
      req_data = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty run, extremes, unfinished point, reads in and out of range
      send_req(make_req(MODE_RUN, 0, 0, 0, 0));
      send_req(make_req(MODE_READ, 0, 0, 0, 0));
      send_req(make_req(MODE_NONE, -1, 1, 7, 15));
      drain();
      csr_write(REG_DIMS, 2);
      send_req(make_req(MODE_LOAD, -8388608, 0, 0, 0));
      send_req(make_req(MODE_LOAD, 8388607, 1, 7, 15));
      send_req(make_req(MODE_LOAD, 8388607, 0, 0, 0));
      send_req(make_req(MODE_LOAD, -8388608, 1, 0, 0));
      send_req(make_req(MODE_LOAD, 0, 0, 0, 0));
      send_req(make_req(MODE_RUN, 0, 0, 0, 0));
      send_req(make_req(MODE_READ, 0, 0, 0, 0));
      send_req(make_req(MODE_READ, 0, 0, 0, 1));
      send_req(make_req(MODE_READ, 0, 0, 1, 0));
      send_req(make_req(MODE_READ, 0, 0, 1, 1));
      send_req(make_req(MODE_READ, 0, 0, 7, 15));
      send_req(make_req(MODE_READ, 0, 0, 2, 0));
      send_req(make_req(MODE_READ, 0, 0, 0, 2));
      drain();

      // random phases, each under its own register setting
      ph = 0;
      while (items_sent < 1950) begin
         if (ph == 6) begin
            // fill the point store, then overflow it
            csr_write(REG_CLUSTERS, 1);
            csr_write(REG_DIMS, 1);
            csr_write(REG_MAX_ITER, 2);
            csr_write(REG_SEED, $urandom_range(1, 65535));
            repeat (NPTS + 3) send_req(make_req(MODE_LOAD, $urandom, 1, $urandom, $urandom));
            send_req(make_req(MODE_READ, 0, 0, 0, 0));
            send_req(make_req(MODE_RUN, 0, 0, 0, 0));
            send_req(make_req(MODE_READ, 0, 0, 0, 0));
         end else begin
            if (ph < 5) begin
               case (ph)
                  0: begin k_val = 0;  n_val = 1;  it_val = 1;     sd_val = 0;     end
                  1: begin k_val = 1;  n_val = 16; it_val = 65535; sd_val = 1;     end
                  2: begin k_val = 8;  n_val = 0;  it_val = 0;     sd_val = 65535; end
                  3: begin k_val = 9;  n_val = 17; it_val = 3;     sd_val = 44257; end
                  default: begin k_val = 15; n_val = 31; it_val = 2; sd_val = 12345; end
               endcase
               if (ph == 4) k_val = 2;
            end else begin
               k_val = $urandom_range(1, 8);
               n_val = $urandom_range(1, 4);
               if ($urandom_range(0, 5) == 0) begin
                  n_val = $urandom_range(5, 16);
                  k_val = $urandom_range(1, 3);
               end
               it_val = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(1, 6);
               sd_val = $urandom_range(1, 65535);
            end
            csr_write(REG_CLUSTERS, k_val);
            csr_write(REG_DIMS, n_val);
            csr_write(REG_MAX_ITER, it_val);
            csr_write(REG_SEED, sd_val);
            groups = $urandom_range(3, 5);
            for (int g = 0; g < groups; g++) point_set_group(ph == 7 && g == 1);
         end
         drain();
         ph++;
      end

      $display("covered %0d requests with %0d runs over %0d register settings",
               items_sent, runs_sent, ph + 1);
      $display("%0d responses checked, %0d mismatches", sb.matched, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
